[rtl/vsob_pkg.sv]
// shared constants and types for the voxel store opacity blend core
// no dependencies
`default_nettype none
package vsob_pkg;
    localparam int VOL_WIDTH_DEF  = 16;
    localparam int VOL_HEIGHT_DEF = 16;
    localparam int VOL_DEPTH_DEF  = 16;

    localparam int COLOR_W   = 8;
    localparam int OPACITY_W = 7;
    localparam int POS_W     = 7;
    localparam int REQ_W     = 2;

    localparam logic [OPACITY_W-1:0] OPACITY_MAX = 7'd100;
    localparam logic [COLOR_W-1:0]   CHANNEL_MAX = 8'd255;

    // stored word: occupied flag, opacity, red, green, blue
    localparam int WORD_W = 1 + OPACITY_W + 3 * COLOR_W;

    typedef enum logic [REQ_W-1:0] {
        REQ_WRITE = 2'd0,
        REQ_READ  = 2'd1,
        REQ_CLEAR = 2'd2,
        REQ_NOP   = 2'd3
    } t_req;
endpackage
`default_nettype wire

[rtl/vsob_if.sv]
// request and result channels of the voxel store core
// depends on vsob_pkg
`default_nettype none
interface vsob_req_if;
    logic                                 valid;
    logic                                 ready;
    logic [vsob_pkg::REQ_W-1:0]           req_type;
    logic signed [vsob_pkg::POS_W-1:0]    pos_x;
    logic signed [vsob_pkg::POS_W-1:0]    pos_y;
    logic signed [vsob_pkg::POS_W-1:0]    pos_z;
    logic [vsob_pkg::COLOR_W-1:0]         red_in;
    logic [vsob_pkg::COLOR_W-1:0]         green_in;
    logic [vsob_pkg::COLOR_W-1:0]         blue_in;
    logic [vsob_pkg::OPACITY_W-1:0]       opacity_in;
    modport source (output valid, req_type, pos_x, pos_y, pos_z, red_in, green_in,
                    blue_in, opacity_in, input ready);
    modport sink (input valid, req_type, pos_x, pos_y, pos_z, red_in, green_in,
                  blue_in, opacity_in, output ready);
endinterface

interface vsob_res_if;
    logic                         valid;
    logic                         ready;
    logic                         inside_res;
    logic                         hit;
    logic [vsob_pkg::COLOR_W-1:0] red_out;
    logic [vsob_pkg::COLOR_W-1:0] green_out;
    logic [vsob_pkg::COLOR_W-1:0] blue_out;
    modport source (output valid, inside_res, hit, red_out, green_out, blue_out,
                    input ready);
    modport sink (input valid, inside_res, hit, red_out, green_out, blue_out,
                  output ready);
endinterface
`default_nettype wire

[rtl/vsob_ram.sv]
// generic single-port ram with registered read
// no dependencies
`default_nettype none
module vsob_ram #(
    parameter int DATA_W = 32,
    parameter int DEPTH  = 4096
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire                      i_re,
    input  wire [$clog2(DEPTH)-1:0]  i_addr,
    input  wire [DATA_W-1:0]         i_wdata,
    output logic [DATA_W-1:0]        o_rdata
);
    logic [DATA_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_addr];
        end
    end
endmodule
`default_nettype wire

[rtl/voxel_store_opacity_blend_core.sv]
// channel  dir  payload
// i_req    in   req_type, pos_x/y/z, red/green/blue_in, opacity_in
// o_res    out  inside_res, hit, red/green/blue_out
// one request at a time; an in-range read or free-cell write passes idx1, idx2, rd
// and mul before done, an out-of-range request leaves for done after idx2, a nop goes
// straight to done and a blend adds the divide (load then seven restoring steps, the
// eighth folded into the write back). a clear sweeps one ram word a cycle, then goes
// to done; the result register loads from done. after reset the same sweep covers
// every cell with no request taken. a stalled result holds in the output register.
// depends on vsob_pkg, vsob_if, vsob_ram
`default_nettype none
module voxel_store_opacity_blend_core #(
    parameter int VOL_WIDTH  = vsob_pkg::VOL_WIDTH_DEF,
    parameter int VOL_HEIGHT = vsob_pkg::VOL_HEIGHT_DEF,
    parameter int VOL_DEPTH  = vsob_pkg::VOL_DEPTH_DEF
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    vsob_req_if.sink   i_req,
    vsob_res_if.source o_res
);
    localparam int CELLS = VOL_WIDTH * VOL_HEIGHT * VOL_DEPTH;
    localparam int AW    = $clog2(CELLS);
    localparam int RW    = $clog2(VOL_WIDTH * VOL_HEIGHT);
    localparam int CW    = vsob_pkg::COLOR_W;
    localparam int OW    = vsob_pkg::OPACITY_W;

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_IDX1 = 9'b000000010,
        S_IDX2 = 9'b000000100,
        S_RD   = 9'b000001000,
        S_MUL  = 9'b000010000,
        S_DIV  = 9'b000100000,
        S_WR   = 9'b001000000,
        S_CLR  = 9'b010000000,
        S_DONE = 9'b100000000
    } t_state;

    t_state r_state;
    logic   r_clr_req;
    logic [AW-1:0] r_sweep;

    // request capture
    localparam int POS_WL = vsob_pkg::POS_W;
    logic [vsob_pkg::REQ_W-1:0] r_kind;
    logic [POS_WL-1:0]          r_x, r_y, r_z;
    logic [CW-1:0]              r_c [3];
    logic [OW-1:0]              r_op;
    logic                       r_inside;
    logic [RW-1:0]              r_row;
    logic [AW-1:0]              r_idx;

    // blend datapath
    logic [2*CW-1:0] r_hi [3];
    logic [CW-1:0]   r_rem [3];
    logic [CW-1:0]   r_lo [3];
    logic [CW-1:0]   r_div;
    logic [OW-1:0]   r_newop;
    logic [2:0]      r_step;
    logic [CW:0]     rem_sh [3];
    logic            q_bit  [3];
    logic [CW-1:0]   rem_nx [3];

    // staged and output result
    logic            r_res_inside, r_res_hit;
    logic [CW-1:0]   r_res_c [3];
    logic            r_out_valid, r_out_inside, r_out_hit;
    logic [CW-1:0]   r_out_c [3];

    logic                       ram_we, ram_re;
    logic [AW-1:0]              ram_addr;
    logic [vsob_pkg::WORD_W-1:0] ram_wdata, ram_rdata;
    logic                       rd_occ;
    logic [OW-1:0]              rd_op;
    logic [CW-1:0]              rd_c [3];
    logic [OW:0]                op_sum;
    logic                       in_fire, out_free;

    assign in_fire  = i_req.valid && i_req.ready;
    assign out_free = !r_out_valid || o_res.ready;
    assign i_req.ready = (r_state == S_IDLE);

    assign rd_occ   = ram_rdata[vsob_pkg::WORD_W-1];
    assign rd_op    = ram_rdata[3*CW +: OW];
    assign rd_c[0]  = ram_rdata[2*CW +: CW];
    assign rd_c[1]  = ram_rdata[CW +: CW];
    assign rd_c[2]  = ram_rdata[0 +: CW];
    assign op_sum   = {1'b0, rd_op} + {1'b0, r_op};

    always_comb begin
        ram_we    = 1'b0;
        ram_re    = (r_state == S_RD);
        ram_addr  = (r_state == S_CLR) ? r_sweep : r_idx;
        ram_wdata = '0;
        case (r_state)
            S_CLR: ram_we = 1'b1;
            S_MUL: begin
                if (r_kind == vsob_pkg::REQ_WRITE && !rd_occ) begin
                    ram_we    = 1'b1;
                    ram_wdata = {1'b1, r_op, r_c[0], r_c[1], r_c[2]};
                end
            end
            S_WR: begin
                // last quotient bit comes straight from the divide step
                ram_we    = 1'b1;
                ram_wdata = {1'b1, r_newop, r_lo[0][CW-2:0], q_bit[0],
                             r_lo[1][CW-2:0], q_bit[1], r_lo[2][CW-2:0], q_bit[2]};
            end
            default: ;
        endcase
    end

    vsob_ram #(.DATA_W(vsob_pkg::WORD_W), .DEPTH(CELLS)) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_re   (ram_re),
        .i_addr (ram_addr),
        .i_wdata(ram_wdata),
        .o_rdata(ram_rdata)
    );

    // one restoring division step per channel, shared divisor
    for (genvar g = 0; g < 3; g++) begin : g_div
        assign rem_sh[g] = {r_rem[g], r_lo[g][CW-1]};
        assign q_bit[g]  = rem_sh[g] >= {1'b0, r_div};
        assign rem_nx[g] = q_bit[g] ? CW'(rem_sh[g] - {1'b0, r_div}) : rem_sh[g][CW-1:0];
    end

    t_state n_state;
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    case (vsob_pkg::t_req'(i_req.req_type))
                        vsob_pkg::REQ_WRITE, vsob_pkg::REQ_READ: n_state = S_IDX1;
                        vsob_pkg::REQ_CLEAR: n_state = S_CLR;
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_IDX1: n_state = S_IDX2;
            S_IDX2: n_state = r_inside ? S_RD : S_DONE;
            S_RD:   n_state = S_MUL;
            S_MUL: begin
                if (r_kind == vsob_pkg::REQ_WRITE && rd_occ && op_sum != '0) begin
                    n_state = S_DIV;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DIV:  n_state = (r_step == 3'd7) ? S_WR : S_DIV;
            S_WR:   n_state = S_DONE;
            S_CLR: begin
                if (r_sweep == AW'(CELLS - 1)) begin
                    n_state = r_clr_req ? S_DONE : S_IDLE;
                end
            end
            S_DONE: n_state = out_free ? S_IDLE : S_DONE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr_req   <= 1'b0;
            r_sweep     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLR) begin
                r_sweep <= (r_sweep == AW'(CELLS - 1)) ? '0 : r_sweep + 1'b1;
            end
            if (in_fire) begin
                r_clr_req <= (i_req.req_type == vsob_pkg::REQ_CLEAR);
            end
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_kind   <= i_req.req_type;
                r_x      <= i_req.pos_x;
                r_y      <= i_req.pos_y;
                r_z      <= i_req.pos_z;
                r_c[0]   <= i_req.red_in;
                r_c[1]   <= i_req.green_in;
                r_c[2]   <= i_req.blue_in;
                r_op     <= i_req.opacity_in;
                r_inside <= 1'b0;
                r_res_inside <= 1'b0;
                r_res_hit    <= 1'b0;
                for (int i = 0; i < 3; i++) r_res_c[i] <= '0;
            end
            S_IDX1: begin
                r_inside <= !r_x[POS_WL-1] && ({1'b0, r_x} < (POS_WL+1)'(VOL_WIDTH))
                         && !r_y[POS_WL-1] && ({1'b0, r_y} < (POS_WL+1)'(VOL_HEIGHT))
                         && !r_z[POS_WL-1] && ({1'b0, r_z} < (POS_WL+1)'(VOL_DEPTH));
                r_row <= RW'(RW'(r_y[POS_WL-2:0]) * RW'(VOL_WIDTH) + RW'(r_x[POS_WL-2:0]));
            end
            S_IDX2: begin
                r_idx <= AW'(AW'(r_row) * AW'(VOL_DEPTH) + AW'(r_z[POS_WL-2:0]));
            end
            S_MUL: begin
                r_res_inside <= 1'b1;
                if (r_kind == vsob_pkg::REQ_READ) begin
                    r_res_hit <= rd_occ;
                    for (int i = 0; i < 3; i++) begin
                        r_res_c[i] <= rd_occ ? rd_c[i] : vsob_pkg::CHANNEL_MAX;
                    end
                end
                for (int i = 0; i < 3; i++) begin
                    // numerator split: high byte seeds the remainder
                    r_hi[i] <= 16'(rd_c[i] * rd_op) + 16'(r_c[i] * r_op);
                end
                r_div   <= CW'(op_sum);
                r_newop <= (op_sum > {1'b0, vsob_pkg::OPACITY_MAX})
                         ? vsob_pkg::OPACITY_MAX : op_sum[OW-1:0];
                r_step  <= '0;
            end
            S_DIV: begin
                r_step <= r_step + 1'b1;
                for (int i = 0; i < 3; i++) begin
                    if (r_step == '0) begin
                        // first step works from the captured numerator
                        r_rem[i] <= r_hi[i][2*CW-1:CW];
                        r_lo[i]  <= r_hi[i][CW-1:0];
                    end else begin
                        r_rem[i] <= rem_nx[i];
                        r_lo[i]  <= {r_lo[i][CW-2:0], q_bit[i]};
                    end
                end
            end
            S_WR: begin
                for (int i = 0; i < 3; i++) begin
                    r_rem[i] <= rem_nx[i];
                    r_lo[i]  <= {r_lo[i][CW-2:0], q_bit[i]};
                end
            end
            default: ;
        endcase
        if (r_state == S_DONE && out_free) begin
            r_out_inside <= r_res_inside;
            r_out_hit    <= r_res_hit;
            for (int i = 0; i < 3; i++) r_out_c[i] <= r_res_c[i];
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.inside_res = r_out_inside;
    assign o_res.hit        = r_out_hit;
    assign o_res.red_out    = r_out_c[0];
    assign o_res.green_out  = r_out_c[1];
    assign o_res.blue_out   = r_out_c[2];

`ifndef NO_ASSERTIONS
    a_we_states: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == S_CLR || r_state == S_MUL || r_state == S_WR))
        else $error("ram written outside a write state");
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && r_step != '0) |-> (r_rem[0] < r_div))
        else $error("division remainder not below divisor");
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> !i_req.ready)
        else $error("request taken while another is in flight");
    a_opacity_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WR) |-> (r_newop <= vsob_pkg::OPACITY_MAX))
        else $error("blended opacity above limit");
`endif
endmodule
`default_nettype wire

[dv/voxel_store_opacity_blend_core_tb.sv]
// self-checking testbench for the voxel store opacity blend core
// depends on vsob_pkg, vsob_if and the core rtl
`timescale 1ns / 100ps
`default_nettype none
module voxel_store_opacity_blend_core_tb;
    localparam int NX = vsob_pkg::VOL_WIDTH_DEF;
    localparam int NY = vsob_pkg::VOL_HEIGHT_DEF;
    localparam int NZ = vsob_pkg::VOL_DEPTH_DEF;
    localparam int CELLS = NX * NY * NZ;
    localparam int CYCLE_LIMIT = 900000;
    localparam int PW = vsob_pkg::POS_W;
    localparam int CW = vsob_pkg::COLOR_W;
    localparam int OW = vsob_pkg::OPACITY_W;

    typedef struct packed {
        vsob_pkg::t_req        kind;
        logic signed [PW-1:0]  x;
        logic signed [PW-1:0]  y;
        logic signed [PW-1:0]  z;
        logic [CW-1:0]         r;
        logic [CW-1:0]         g;
        logic [CW-1:0]         b;
        logic [OW-1:0]         op;
    } t_request;

    typedef struct packed {
        logic          in_range;
        logic          hit;
        logic [CW-1:0] r;
        logic [CW-1:0] g;
        logic [CW-1:0] b;
    } t_answer;

    typedef struct packed {
        t_request rq;
        logic     typed;
        t_answer  ans;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    always #1 i_clk = ~i_clk;

    vsob_req_if req_ch();
    vsob_res_if res_ch();

    voxel_store_opacity_blend_core dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_ch.sink),
        .o_res  (res_ch.source)
    );

    // mirror of the volume
    logic [CW-1:0] cell_r  [CELLS];
    logic [CW-1:0] cell_g  [CELLS];
    logic [CW-1:0] cell_b  [CELLS];
    logic [OW-1:0] cell_op [CELLS];
    logic          cell_used [CELLS];

    t_answer answers_due[$];
    int      errors = 0;
    int      send_idle_pct = 11;
    int      recv_idle_pct = 61;
    bit      hold_results = 1'b0;
    int      cycles = 0;

    function automatic logic [CW-1:0] mix_channel(logic [CW-1:0] old_c,
            int o, logic [CW-1:0] c, int op);
        if (o + op == 0) return old_c;
        return CW'((int'(old_c) * o + int'(c) * op) / (o + op));
    endfunction

    function automatic t_answer apply_request(t_request rq);
        t_answer a;
        int idx, o, sum;
        logic in_vol;
        a = '0;
        in_vol = rq.x >= 0 && rq.x < NX && rq.y >= 0 && rq.y < NY
                 && rq.z >= 0 && rq.z < NZ;
        idx = in_vol ? ((int'(rq.y) * NX + int'(rq.x)) * NZ + int'(rq.z)) : 0;
        case (rq.kind)
            vsob_pkg::REQ_WRITE: if (in_vol) begin
                a.in_range = 1'b1;
                if (!cell_used[idx]) begin
                    cell_r[idx] = rq.r; cell_g[idx] = rq.g; cell_b[idx] = rq.b;
                    cell_op[idx] = rq.op;
                    cell_used[idx] = 1'b1;
                end else begin
                    o = int'(cell_op[idx]);
                    cell_r[idx] = mix_channel(cell_r[idx], o, rq.r, int'(rq.op));
                    cell_g[idx] = mix_channel(cell_g[idx], o, rq.g, int'(rq.op));
                    cell_b[idx] = mix_channel(cell_b[idx], o, rq.b, int'(rq.op));
                    sum = o + int'(rq.op);
                    cell_op[idx] = sum > int'(vsob_pkg::OPACITY_MAX)
                                 ? vsob_pkg::OPACITY_MAX : OW'(sum);
                end
            end
            vsob_pkg::REQ_READ: if (in_vol) begin
                a.in_range = 1'b1;
                a.hit = cell_used[idx];
                a.r = cell_used[idx] ? cell_r[idx] : vsob_pkg::CHANNEL_MAX;
                a.g = cell_used[idx] ? cell_g[idx] : vsob_pkg::CHANNEL_MAX;
                a.b = cell_used[idx] ? cell_b[idx] : vsob_pkg::CHANNEL_MAX;
            end
            vsob_pkg::REQ_CLEAR: foreach (cell_used[i]) cell_used[i] = 1'b0;
            default: ;
        endcase
        return a;
    endfunction

    function automatic t_request any_request(int in_pct);
        t_request rq;
        int k;
        k = int'($urandom_range(99));
        rq.kind = k < 50 ? vsob_pkg::REQ_WRITE : k < 92 ? vsob_pkg::REQ_READ
                : k < 95 ? vsob_pkg::REQ_CLEAR : vsob_pkg::REQ_NOP;
        if (int'($urandom_range(99)) < in_pct) begin
            // small corner of the volume so blends and hits are common
            rq.x = PW'($urandom_range(3)); rq.y = PW'($urandom_range(3));
            rq.z = PW'($urandom_range(3));
            if ($urandom_range(3) == 0) begin
                rq.x = PW'($urandom_range(NX - 1)); rq.y = PW'($urandom_range(NY - 1));
                rq.z = PW'($urandom_range(NZ - 1));
            end
        end else begin
            rq.x = PW'($urandom); rq.y = PW'($urandom); rq.z = PW'($urandom);
        end
        rq.r = CW'($urandom); rq.g = CW'($urandom); rq.b = CW'($urandom);
        rq.op = $urandom_range(9) == 0 ? OW'($urandom) : OW'($urandom_range(100));
        return rq;
    endfunction

    task automatic send_request(t_request rq);
        while (int'($urandom_range(99)) < send_idle_pct) @(negedge i_clk);
        req_ch.valid    = 1'b1;
        req_ch.req_type = rq.kind;
        req_ch.pos_x = rq.x; req_ch.pos_y = rq.y; req_ch.pos_z = rq.z;
        req_ch.red_in = rq.r; req_ch.green_in = rq.g; req_ch.blue_in = rq.b;
        req_ch.opacity_in = rq.op;
        do @(posedge i_clk); while (!req_ch.ready);
        @(negedge i_clk);
        req_ch.valid = 1'b0;
    endtask

    task automatic wait_drained();
        while (answers_due.size() != 0) @(negedge i_clk);
    endtask

    // receiver side
    always @(negedge i_clk) begin
        if (hold_results) res_ch.ready <= 1'b0;
        else res_ch.ready <= int'($urandom_range(99)) >= recv_idle_pct;
    end

    always @(posedge i_clk) begin
        t_answer want, got;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            got = '{res_ch.inside_res, res_ch.hit, res_ch.red_out,
                    res_ch.green_out, res_ch.blue_out};
            if (answers_due.size() == 0) begin
                $display("%0t unexpected result %h", $time, got);
                errors++;
            end else begin
                want = answers_due.pop_front();
                if (got !== want) begin
                    $display("%0t mismatch exp inside %b hit %b rgb %h %h %h",
                             $time, want.in_range, want.hit, want.r, want.g, want.b);
                    $display("%0t          got inside %b hit %b rgb %h %h %h",
                             $time, got.in_range, got.hit, got.r, got.g, got.b);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("[voxel_store_opacity_blend_core] ERROR");
            $finish;
        end
    end

    function automatic t_request mk(vsob_pkg::t_req k, int x, int y, int z, int r, int g,
            int b, int op);
        t_request rq;
        rq.kind = k;
        rq.x = PW'(x); rq.y = PW'(y); rq.z = PW'(z);
        rq.r = CW'(r); rq.g = CW'(g); rq.b = CW'(b);
        rq.op = OW'(op);
        return rq;
    endfunction

    t_row directed[$];

    task automatic run_phase(int n);
        t_request rq;
        repeat (n) begin
            rq = any_request(85);
            answers_due.push_back(apply_request(rq));
            send_request(rq);
        end
    endtask

    initial begin
        t_answer a;
        t_answer zero_ans;
        t_answer white;
        zero_ans = '0;
        white = '{1'b1, 1'b0, 8'hff, 8'hff, 8'hff};
        foreach (cell_used[i]) begin
            cell_used[i] = 1'b0; cell_r[i] = '0; cell_g[i] = '0; cell_b[i] = '0;
            cell_op[i] = '0;
        end
        req_ch.valid = 1'b0;
        req_ch.req_type = vsob_pkg::REQ_NOP;
        req_ch.pos_x = '0; req_ch.pos_y = '0; req_ch.pos_z = '0;
        req_ch.red_in = '0; req_ch.green_in = '0; req_ch.blue_in = '0;
        req_ch.opacity_in = '0;
        res_ch.ready = 1'b0;

        // directed rows: fixed answers where plain, otherwise predictor
        directed = '{
            '{mk(vsob_pkg::REQ_READ, 0, 0, 0, 0, 0, 0, 0), 1'b1, white},
            '{mk(vsob_pkg::REQ_READ, NX-1, NY-1, NZ-1, 0, 0, 0, 0), 1'b1, white},
            '{mk(vsob_pkg::REQ_READ, -1, 0, 0, 0, 0, 0, 0), 1'b1, zero_ans},
            '{mk(vsob_pkg::REQ_READ, 0, 63, 0, 0, 0, 0, 0), 1'b1, zero_ans},
            '{mk(vsob_pkg::REQ_READ, 0, 0, -64, 0, 0, 0, 0), 1'b1, zero_ans},
            '{mk(vsob_pkg::REQ_WRITE, NX, 0, 0, 255, 255, 255, 100), 1'b1, zero_ans},
            '{mk(vsob_pkg::REQ_WRITE, 0, 0, 0, 255, 0, 170, 100), 1'b1,
              '{1'b1, 1'b0, 8'h0, 8'h0, 8'h0}},
            '{mk(vsob_pkg::REQ_READ, 0, 0, 0, 0, 0, 0, 0), 1'b1,
              '{1'b1, 1'b1, 8'hff, 8'h00, 8'haa}},
            '{mk(vsob_pkg::REQ_WRITE, 0, 0, 0, 0, 255, 85, 100), 1'b0, zero_ans},
            '{mk(vsob_pkg::REQ_READ, 0, 0, 0, 0, 0, 0, 0), 1'b0, zero_ans},
            '{mk(vsob_pkg::REQ_WRITE, 1, 0, 0, 10, 20, 30, 0), 1'b0, zero_ans},
            '{mk(vsob_pkg::REQ_WRITE, 1, 0, 0, 90, 80, 70, 0), 1'b0, zero_ans},
            '{mk(vsob_pkg::REQ_READ, 1, 0, 0, 0, 0, 0, 0), 1'b0, zero_ans},
            '{mk(vsob_pkg::REQ_WRITE, NX-1, NY-1, NZ-1, 255, 255, 255, 127), 1'b0, zero_ans},
            '{mk(vsob_pkg::REQ_WRITE, NX-1, NY-1, NZ-1, 0, 0, 0, 127), 1'b0, zero_ans},
            '{mk(vsob_pkg::REQ_READ, NX-1, NY-1, NZ-1, 0, 0, 0, 0), 1'b0, zero_ans},
            '{mk(vsob_pkg::REQ_NOP, 0, 0, 0, 255, 255, 255, 127), 1'b1, zero_ans},
            '{mk(vsob_pkg::REQ_CLEAR, -64, 63, 5, 1, 2, 3, 4), 1'b1, zero_ans},
            '{mk(vsob_pkg::REQ_READ, 0, 0, 0, 0, 0, 0, 0), 1'b1, white},
            '{mk(vsob_pkg::REQ_WRITE, 0, 0, 0, 1, 2, 3, 50), 1'b0, zero_ans},
            '{mk(vsob_pkg::REQ_READ, 0, 0, 0, 0, 0, 0, 0), 1'b1,
              '{1'b1, 1'b1, 8'd1, 8'd2, 8'd3}}
        };

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed[i]) begin
            a = apply_request(directed[i].rq);
            answers_due.push_back(directed[i].typed ? directed[i].ans : a);
            send_request(directed[i].rq);
        end

        run_phase(130);
        send_idle_pct = 61; recv_idle_pct = 11;
        run_phase(130);

        // sender pauses until everything is back
        wait_drained();

        // long receiver hold while the sender keeps offering requests
        fork
            begin
                hold_results = 1'b1;
                repeat (300) @(negedge i_clk);
                hold_results = 1'b0;
            end
            begin
                send_idle_pct = 0;
                run_phase(10);
            end
        join

        send_idle_pct = 0; recv_idle_pct = 0;
        run_phase(130);

        wait_drained();
        repeat (CELLS + 40) @(negedge i_clk);
        if (errors == 0 && answers_due.size() == 0) begin
            $display("[voxel_store_opacity_blend_core] OK");
        end else begin
            $display("[voxel_store_opacity_blend_core] ERROR");
        end
        $finish;
    end
endmodule
`default_nettype wire

[sim.f]
rtl/vsob_pkg.sv
rtl/vsob_if.sv
rtl/vsob_ram.sv
rtl/voxel_store_opacity_blend_core.sv
dv/voxel_store_opacity_blend_core_tb.sv
